// ----- src/utc_pkg.sv -----
// shared types, constants and the charset mapping function for the utf-8 decoder
package utc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  CHAR_SPACE    = 8'h20;
  localparam logic [7:0]  CHAR_QUESTION = 8'h3F;
  localparam logic [15:0] CODE_QUESTION = 16'h003F;

  // one decoded code point travelling from the front end to the back end
  typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        trunc;  // three-byte lead cut short: '?' comes first
  } utc_entry_t;

  typedef enum logic [1:0] {
    NEED_NONE = 2'd0,
    NEED_ONE  = 2'd1,
    NEED_TWO  = 2'd2
  } utc_need_t;

  function automatic logic [7:0] map_code(input logic [15:0] cp);
    logic [7:0] ch;
    ch = CHAR_QUESTION;
    if (cp < 16'h0020 && cp != 16'h000A && cp != 16'h000D) begin
      ch = CHAR_SPACE;
    end else if (cp < 16'h0080) begin
      ch = cp[7:0];
    end else begin
      case (cp)
        16'h00C1: ch = 8'h8A;  16'h00C0: ch = 8'h8B;
        16'h00C2: ch = 8'h8C;  16'h00C4: ch = 8'h8D;
        16'h00E1: ch = 8'h8E;  16'h00E0: ch = 8'h8F;
        16'h00E2: ch = 8'h90;  16'h00E4: ch = 8'h91;
        16'h00C9: ch = 8'h92;  16'h00C8: ch = 8'h93;
        16'h00CA: ch = 8'h94;  16'h00CB: ch = 8'h95;
        16'h00E9: ch = 8'h96;  16'h00E8: ch = 8'h97;
        16'h00EA: ch = 8'h98;  16'h00EB: ch = 8'h99;
        16'h00CD: ch = 8'h9A;  16'h00CC: ch = 8'h9B;
        16'h00CE: ch = 8'h9C;  16'h00CF: ch = 8'h9D;
        16'h00ED: ch = 8'h9E;  16'h00EC: ch = 8'h9F;
        16'h00D3: ch = 8'hA2;  16'h00D2: ch = 8'hA3;
        16'h00D4: ch = 8'hA4;  16'h00D6: ch = 8'hA5;
        16'h00F3: ch = 8'hA6;  16'h00F2: ch = 8'hA7;
        16'h00F4: ch = 8'hA8;  16'h00F6: ch = 8'hA9;
        16'h00DA: ch = 8'hAA;  16'h00D9: ch = 8'hAB;
        16'h00DB: ch = 8'hAC;  16'h00DC: ch = 8'hAD;
        16'h00FA: ch = 8'hAE;  16'h00F9: ch = 8'hAF;
        16'h00C7: ch = 8'hB2;  16'h00E7: ch = 8'hB3;
        16'h03B1: ch = 8'hBB;  16'h03B2: ch = 8'hBC;
        16'h03B3: ch = 8'hBD;  16'h0394: ch = 8'hBE;
        16'h03B4: ch = 8'hBF;  16'h03B5: ch = 8'hC0;
        16'h03B8: ch = 8'h5B;  16'h03BB: ch = 8'hC2;
        16'h03BC: ch = 8'hC3;  16'h03C0: ch = 8'hC4;
        16'h03C1: ch = 8'hC5;  16'h03A3: ch = 8'hC6;
        16'h03C3: ch = 8'hC7;  16'h03C4: ch = 8'hC8;
        16'h03C6: ch = 8'hC9;  16'h03A9: ch = 8'hCA;
        16'h00E3: ch = 8'h61;  16'h00C3: ch = 8'h41;
        16'h00F5: ch = 8'h6F;  16'h00D5: ch = 8'h4F;
        default:  ch = CHAR_QUESTION;
      endcase
    end
    return ch;
  endfunction

endpackage

// ----- src/utc_front.sv -----
// front end: accepts bytes and assembles utf-8 sequences into code points
module utc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         byte_in,
  input  logic               end_in,
  output logic               push,
  output utc_pkg::utc_entry_t entry
);
  import utc_pkg::*;

  utc_need_t   need_r, need_nxt;
  logic [15:0] partial_r, partial_nxt;

  always_comb begin
    need_nxt    = need_r;
    partial_nxt = partial_r;
    push        = 1'b0;
    entry.code  = CODE_QUESTION;
    entry.last  = end_in;
    entry.trunc = 1'b0;
    case (need_r)
      NEED_NONE: begin
        if (!byte_in[7]) begin
          push       = acc;
          entry.code = {8'h00, byte_in};
        end else if (byte_in[7:5] == 3'b110 && !end_in) begin
          partial_nxt = {5'd0, byte_in[4:0], 6'd0};
          need_nxt    = NEED_ONE;
        end else if (byte_in[7:4] == 4'b1110 && !end_in) begin
          partial_nxt = {byte_in[3:0], 12'd0};
          need_nxt    = NEED_TWO;
        end else begin
          push = acc;
        end
      end
      NEED_TWO: begin
        if (end_in) begin
          push        = acc;
          entry.trunc = 1'b1;
          entry.code  = byte_in[7] ? CODE_QUESTION : {8'h00, byte_in};
          partial_nxt = '0;
          need_nxt    = NEED_NONE;
        end else begin
          partial_nxt = partial_r | {4'd0, byte_in[5:0], 6'd0};
          need_nxt    = NEED_ONE;
        end
      end
      NEED_ONE: begin
        push        = acc;
        entry.code  = partial_r | {10'd0, byte_in[5:0]};
        partial_nxt = '0;
        need_nxt    = NEED_NONE;
      end
      default: begin
        partial_nxt = '0;
        need_nxt    = NEED_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r    <= NEED_NONE;
      partial_r <= '0;
    end else if (acc) begin
      need_r    <= need_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// ----- src/utc_queue.sv -----
// short register queue between the front and back ends
module utc_queue #(
  parameter int unsigned DEPTH = utc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  utc_pkg::utc_entry_t wr_entry,
  output logic               full,
  input  logic               pop,
  output logic               rd_valid,
  output utc_pkg::utc_entry_t rd_entry
);
  import utc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  utc_entry_t    slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ----- src/utc_back.sv -----
// back end: maps code points to charset bytes and drives the output register
module utc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_valid,
  input  utc_pkg::utc_entry_t rd_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_last_char
);
  import utc_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_char_r, pend_char_nxt;
  logic       load_ok;
  logic [7:0] mapped;

  assign load_ok = !valid_r || !out_stall;
  assign mapped  = map_code(rd_entry.code);

  always_comb begin
    valid_nxt     = valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    pend_char_nxt = pend_char_r;
    pop           = 1'b0;
    if (load_ok) begin
      valid_nxt = 1'b0;
      if (pend_r) begin
        // second item of a truncated three-byte sequence
        valid_nxt = 1'b1;
        char_nxt  = pend_char_r;
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (rd_valid) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        if (rd_entry.trunc) begin
          char_nxt      = CHAR_QUESTION;
          last_nxt      = 1'b0;
          pend_nxt      = 1'b1;
          pend_char_nxt = mapped;
        end else begin
          char_nxt = mapped;
          last_nxt = rd_entry.last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    pend_char_r <= pend_char_nxt;
  end

  assign out_valid     = valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;

endmodule

// ----- src/utf8_to_calculator_charset_core.sv -----
// top level of the utf-8 to calculator charset decoder
//
// input channel: one byte of a utf-8 text run per item on in_byte, with
// in_run_end high on the run's last byte; taken when in_valid is high and
// in_stall is low. output channel: one calculator byte per item on out_char,
// with out_last_char high on the final character of a run; taken when
// out_valid is high and out_stall is low.
// the front end assembles one- to three-byte sequences into code points,
// a small queue (QUEUE_DEPTH entries) holds them, and the back end maps each
// code point through the charset table into the output register.
// throughput: one byte per cycle while in_stall is low. a three-byte lead cut
// short by the run end yields two items, which the output register presents
// one after the other. an item that yields a result is written into the queue
// at the edge that accepts its byte and reaches the output register from the
// queue head once that register is empty or out_stall is low.
// in_stall rises only when the queue is full, so a stalled receiver backs the
// queue up and then holds off the sender; nothing is dropped.
// reset (rst_n low, synchronous) empties the queue and the output register
// and forgets any half-assembled sequence.
module utf8_to_calculator_charset_core #(
  parameter int unsigned QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_run_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_char
);
  import utc_pkg::*;

  logic       in_acc;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_rd_valid;
  utc_entry_t q_wr_entry;
  utc_entry_t q_rd_entry;

  // stall only on a full queue; an accepted byte never needs more than one slot
  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  // sequence assembly
  utc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .byte_in (in_byte),
    .end_in  (in_run_end),
    .push    (q_push),
    .entry   (q_wr_entry)
  );

  // decouples the front end from output back-pressure
  utc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_rd_valid),
    .rd_entry (q_rd_entry)
  );

  // charset mapping and output register
  utc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_valid      (q_rd_valid),
    .rd_entry      (q_rd_entry),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule
